@@ sv/aprs_pkg.sv @@
// Shared types and constants of the aged priority request scheduler.
// No dependencies; the interfaces and the top level import this package.
package aprs_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int AGE_CAP_DEF = 20000;
  localparam int SCORE_W     = 34;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  typedef enum logic [2:0] {
    ACT_REGISTER   = 3'd0,
    ACT_UNREGISTER = 3'd1,
    ACT_SUBMIT     = 3'd2,
    ACT_DISPATCH   = 3'd3,
    ACT_COMPLETE   = 3'd4,
    ACT_TAKE       = 3'd5,
    ACT_FLUSH      = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_REJECTED = 2'd1,
    ST_NONE     = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GEN_ENABLED = 2'd0,
    REG_MAX_AGENTS  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        latest;
    logic [31:0]        qtime;
    logic signed [23:0] prio;
    logic [15:0]        tag;
  } slot_word_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] seq;
    logic        succ;
  } result_word_t;

endpackage

@@ sv/aprs_if.sv @@
// Channel interfaces of the scheduler: request, response and configuration.
// Depends on aprs_pkg.
interface aprs_req_if import aprs_pkg::*; ();
  logic               valid;
  logic               ready;
  action_t            action;
  logic [3:0]         slot;
  logic [31:0]        now_time;
  logic [31:0]        sequence_req;
  logic signed [23:0] priority_req;
  logic [15:0]        tag;
  logic [7:0]         generation;
  logic               success;
  modport source(output valid, action, slot, now_time, sequence_req, priority_req, tag,
                 generation, success, input ready);
  modport sink(input valid, action, slot, now_time, sequence_req, priority_req, tag,
               generation, success, output ready);
endinterface

interface aprs_rsp_if import aprs_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [3:0]  out_slot;
  logic [31:0] out_sequence;
  logic [15:0] out_tag;
  logic        out_success;
  logic [7:0]  out_generation;
  logic        slot_busy;
  logic [4:0]  agent_count;
  logic [4:0]  pending_count;
  logic [4:0]  executing_count;
  logic [31:0] call_count;
  logic [31:0] failure_count;
  modport source(output valid, status, out_slot, out_sequence, out_tag, out_success,
                 out_generation, slot_busy, agent_count, pending_count, executing_count,
                 call_count, failure_count, input ready);
  modport sink(input valid, status, out_slot, out_sequence, out_tag, out_success,
               out_generation, slot_busy, agent_count, pending_count, executing_count,
               call_count, failure_count, output ready);
endinterface

interface aprs_cfg_if import aprs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ sv/aged_priority_request_scheduler.sv @@
// Top level of the aged priority request scheduler: slot table, dispatch scan.
// Depends on aprs_pkg, aprs_if and aprs_ram.
//
//  channel  direction  handshake      payload
//  req      in         valid/ready    action, slot, now_time, sequence_req, priority_req,
//                                     tag, generation, success
//  rsp      out        valid/ready    status, out_slot, out_sequence through failure_count
//  cfg      in         valid/ready    index, data (always ready)
//
// One item at a time. Register, unregister, submit, complete, take and flush pass
// through accept with the slot RAM read, read-modify-write and response load.
// Dispatch scans the slot RAM one entry per cycle, then reads back and updates the
// picked entry when one is found, else goes straight to the response load.
// Synchronous reset clears all flags, counts and the generation; no RAM clearing.
// A held response lets one more item in; that item waits for the response load and
// the input stalls until the held response leaves.
module aged_priority_request_scheduler import aprs_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int AGE_CAP = AGE_CAP_DEF
) (
  input logic          clk,
  input logic          rst,
  aprs_req_if.sink     req,
  aprs_rsp_if.source   rsp,
  aprs_cfg_if.sink     cfg
);
  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_PICKRD = 6'b001000,
    S_PICK   = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t state;

  logic             gen_enabled;
  logic [4:0]       max_agents;

  logic [SLOTS-1:0] registered, pending, executing, res_valid;
  logic [CW-1:0]    agent_cnt, pend_cnt, exec_cnt;
  logic [7:0]       cur_gen;
  logic [31:0]      call_cnt, fail_cnt;

  action_t            q_action;
  logic [3:0]         q_slot;
  logic [31:0]        q_now, q_seq;
  logic signed [23:0] q_prio;
  logic [15:0]        q_tag;
  logic [7:0]         q_gen;
  logic               q_succ;

  status_t     r_status;
  logic [3:0]  r_slot;
  logic [SW-1:0] r_bidx;
  logic        r_bvalid;
  logic [31:0] r_seq;
  logic [15:0] r_tag;
  logic        r_succ;
  logic [7:0]  r_gen;

  logic [SW:0]   cnt;
  logic          v1, v2, pend2, found;
  logic [SW-1:0] i1, i2, pick;
  logic [31:0]   age2;
  logic signed [23:0] prio2;
  logic signed [SCORE_W-1:0] best, score;

  slot_word_t   slot_wdata, slot_rdata;
  result_word_t res_wdata, res_rdata;
  logic         slot_we, res_we;
  logic [SW-1:0] slot_waddr, raddr, q_idx, in_idx, free_idx;
  logic         free_found, slot_in, slot_reg, reg_ok, sub_ok, cmp_ok;
  logic [31:0]  age_raw, age_cap;

  assign q_idx   = SW'(q_slot);
  assign in_idx  = SW'(req.slot);
  assign slot_in = 32'(q_slot) < SLOTS;
  assign slot_reg = slot_in && registered[q_idx];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!registered[s]) begin
        free_found = 1'b1;
        free_idx   = SW'(s);
      end
    end
  end

  assign reg_ok = (32'(agent_cnt) < 32'(max_agents)) && free_found;
  assign sub_ok = slot_reg && gen_enabled && (q_seq != '0) && (q_seq > slot_rdata.latest);
  assign cmp_ok = slot_reg && executing[q_idx] && (q_gen == cur_gen)
                  && (q_seq == slot_rdata.latest);

  always_comb begin
    case (state)
      S_IDLE:   raddr = in_idx;
      S_SCAN:   raddr = cnt[SW-1:0];
      S_PICKRD: raddr = pick;
      default:  raddr = q_idx;
    endcase
  end

  assign slot_we    = (state == S_EXEC) && (((q_action == ACT_REGISTER) && reg_ok)
                      || ((q_action == ACT_SUBMIT) && sub_ok));
  assign slot_waddr = (q_action == ACT_REGISTER) ? free_idx : q_idx;
  always_comb begin
    slot_wdata        = '0;
    if (q_action == ACT_SUBMIT) begin
      slot_wdata.latest = q_seq;
      slot_wdata.qtime  = pending[q_idx] ? slot_rdata.qtime : q_now;
      slot_wdata.prio   = q_prio;
      slot_wdata.tag    = q_tag;
    end
  end

  assign res_we    = (state == S_EXEC) && (q_action == ACT_COMPLETE) && cmp_ok;
  assign res_wdata = '{tag: q_tag, seq: q_seq, succ: q_succ};

  aprs_ram #(.WIDTH($bits(slot_word_t)), .DEPTH(SLOTS)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(raddr), .rdata(slot_rdata)
  );

  aprs_ram #(.WIDTH($bits(result_word_t)), .DEPTH(SLOTS)) u_res_ram (
    .clk(clk), .we(res_we), .waddr(q_idx), .wdata(res_wdata),
    .raddr(raddr), .rdata(res_rdata)
  );

  assign age_raw = q_now - slot_rdata.qtime;
  assign age_cap = (age_raw > 32'(AGE_CAP)) ? 32'(AGE_CAP) : age_raw;
  assign score   = SCORE_W'(prio2) + SCORE_W'(age2);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_enabled <= 1'b0;
      max_agents  <= 5'd16;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GEN_ENABLED: gen_enabled <= cfg.data[0];
        REG_MAX_AGENTS:  max_agents  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      registered <= '0;
      pending    <= '0;
      executing  <= '0;
      res_valid  <= '0;
      agent_cnt  <= '0;
      pend_cnt   <= '0;
      exec_cnt   <= '0;
      cur_gen    <= '0;
      call_cnt   <= '0;
      fail_cnt   <= '0;
      rsp.valid  <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      found      <= 1'b0;
      cnt        <= '0;
    end else begin
      if (rsp.valid && rsp.ready && (state != S_FIN)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            q_action <= req.action;
            q_slot   <= req.slot;
            q_now    <= req.now_time;
            q_seq    <= req.sequence_req;
            q_prio   <= req.priority_req;
            q_tag    <= req.tag;
            q_gen    <= req.generation;
            q_succ   <= req.success;
            r_status <= ST_REJECTED;
            r_slot   <= req.slot;
            r_bidx   <= in_idx;
            r_bvalid <= 32'(req.slot) < SLOTS;
            r_seq    <= '0;
            r_tag    <= '0;
            r_succ   <= 1'b0;
            r_gen    <= '0;
            cnt      <= '0;
            v1       <= 1'b0;
            v2       <= 1'b0;
            found    <= 1'b0;
            state    <= (req.action == ACT_DISPATCH) ? S_SCAN : S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_FIN;
          case (q_action)
            ACT_REGISTER: begin
              r_slot   <= '0;
              r_bidx   <= '0;
              r_bvalid <= 1'b1;
              if (reg_ok) begin
                registered[free_idx] <= 1'b1;
                agent_cnt <= agent_cnt + 1'b1;
                r_slot    <= 4'(free_idx);
                r_bidx    <= free_idx;
                r_status  <= ST_DONE;
              end
            end
            ACT_UNREGISTER: begin
              if (slot_reg) begin
                registered[q_idx] <= 1'b0;
                pending[q_idx]    <= 1'b0;
                executing[q_idx]  <= 1'b0;
                res_valid[q_idx]  <= 1'b0;
                agent_cnt <= agent_cnt - 1'b1;
                pend_cnt  <= pend_cnt - CW'(pending[q_idx]);
                exec_cnt  <= exec_cnt - CW'(executing[q_idx]);
                r_status  <= ST_DONE;
              end
            end
            ACT_SUBMIT: begin
              if (sub_ok) begin
                pending[q_idx] <= 1'b1;
                pend_cnt <= pend_cnt + CW'(!pending[q_idx]);
                r_status <= ST_DONE;
              end
            end
            ACT_COMPLETE: begin
              if (gen_enabled) begin
                call_cnt <= call_cnt + 1'b1;
                if (!q_succ) begin
                  fail_cnt <= fail_cnt + 1'b1;
                end
              end
              if (slot_reg) begin
                executing[q_idx] <= 1'b0;
                exec_cnt <= exec_cnt - CW'(executing[q_idx]);
                if (cmp_ok) begin
                  res_valid[q_idx] <= 1'b1;
                  r_status <= ST_DONE;
                end
              end
            end
            ACT_TAKE: begin
              if (slot_reg) begin
                if (res_valid[q_idx]) begin
                  res_valid[q_idx] <= 1'b0;
                  r_seq    <= res_rdata.seq;
                  r_tag    <= res_rdata.tag;
                  r_succ   <= res_rdata.succ;
                  r_status <= ST_DONE;
                end else begin
                  r_status <= ST_NONE;
                end
              end
            end
            ACT_FLUSH: begin
              cur_gen   <= cur_gen + 1'b1;
              pending   <= '0;
              res_valid <= '0;
              pend_cnt  <= '0;
              r_status  <= ST_DONE;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          v1 <= 32'(cnt) < SLOTS;
          i1 <= cnt[SW-1:0];
          if (32'(cnt) < SLOTS) begin
            cnt <= cnt + 1'b1;
          end
          v2    <= v1;
          i2    <= i1;
          pend2 <= v1 && pending[i1];
          age2  <= age_cap;
          prio2 <= slot_rdata.prio;
          if (v2 && pend2 && (!found || (score > best))) begin
            found <= 1'b1;
            best  <= score;
            pick  <= i2;
          end
          if (!(32'(cnt) < SLOTS) && !v1 && !v2) begin
            r_slot   <= '0;
            r_bidx   <= '0;
            r_bvalid <= 1'b1;
            r_status <= ST_NONE;
            state    <= found ? S_PICKRD : S_FIN;
          end
        end
        S_PICKRD: begin
          state <= S_PICK;
        end
        S_PICK: begin
          pending[pick]   <= 1'b0;
          executing[pick] <= 1'b1;
          pend_cnt <= pend_cnt - 1'b1;
          exec_cnt <= exec_cnt + CW'(!executing[pick]);
          r_slot   <= 4'(pick);
          r_bidx   <= pick;
          r_seq    <= slot_rdata.latest;
          r_tag    <= slot_rdata.tag;
          r_gen    <= cur_gen;
          r_status <= ST_DONE;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid           <= 1'b1;
            rsp.status          <= r_status;
            rsp.out_slot        <= r_slot;
            rsp.out_sequence    <= r_seq;
            rsp.out_tag         <= r_tag;
            rsp.out_success     <= r_succ;
            rsp.out_generation  <= r_gen;
            rsp.slot_busy       <= r_bvalid && (pending[r_bidx] || executing[r_bidx]);
            rsp.agent_count     <= 5'(agent_cnt);
            rsp.pending_count   <= 5'(pend_cnt);
            rsp.executing_count <= 5'(exec_cnt);
            rsp.call_count      <= call_cnt;
            rsp.failure_count   <= fail_cnt;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/aprs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module aprs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
